>>> design/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Shared types, constants and the microcode program of the range sequencer.
// ----------------------------------------------------------------------------
package urs_pkg;

  // Field and counter widths
  localparam int unsigned CNT_W    = 24;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned ECNT_W   = 16;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned PC_W     = 5;
  localparam int unsigned DCNT_W   = 5;
  localparam int unsigned QSAT_W   = 10;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned REM100_W = 7;

  // Configuration port
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REGIDX_W = 3;

  localparam logic [REGIDX_W-1:0] REG_TRIGGER_TICKS  = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_WAIT_TIMEOUT   = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_ECHO_TIMEOUT   = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_TICKS_PER_UNIT = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_GAP_TICKS      = 3'd4;

  // Register reset values
  localparam logic [THR_W-1:0] RST_TRIGGER_TICKS  = 16'd20;
  localparam logic [THR_W-1:0] RST_WAIT_TIMEOUT   = 16'd60000;
  localparam logic [THR_W-1:0] RST_ECHO_TIMEOUT   = 16'd60000;
  localparam logic [THR_W-1:0] RST_TICKS_PER_UNIT = 16'd116;
  localparam logic [CNT_W-1:0] RST_GAP_TICKS      = 24'd120000;

  // Report arithmetic
  localparam logic [ECNT_W-1:0] ECNT_MAX   = 16'hFFFF;
  localparam logic [ECNT_W-1:0] QUOT_MAX   = 16'd999;
  localparam logic [DCNT_W-1:0] DIV_STEPS  = 5'd16;
  localparam logic [5:0]        RECIP_100  = 6'd41;   // q*41 >> 12 == q/100 for q < 1000
  localparam logic [7:0]        RECIP_10   = 8'd205;  // r*205 >> 11 == r/10 for r < 100
  localparam logic [6:0]        HUNDRED    = 7'd100;
  localparam logic [3:0]        TEN        = 4'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 7'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 7'd10;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_MEASURE = 2'd2,
    PH_GAP     = 2'd3
  } phase_e;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_TRIG_UPD,
    OP_WAIT_UPD,
    OP_GAP_UPD,
    OP_MEAS_START,
    OP_MEAS_UPD,
    OP_REP_INIT,
    OP_DIV_STEP,
    OP_SAT,
    OP_HUND,
    OP_REM,
    OP_TENS,
    OP_ONES,
    OP_EMIT_HUND,
    OP_EMIT_TENS,
    OP_EMIT_ONES,
    OP_EMIT_CR,
    OP_EMIT_LF,
    OP_EMIT_IDLE,
    OP_EMIT_TRIG
  } op_e;

  // Step hold conditions
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_e;

  // Jump conditions
  typedef enum logic [3:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_PH_TRIG,
    JC_PH_WAIT,
    JC_PH_MEAS,
    JC_ECHO,
    JC_NO_ECHO,
    JC_ECHO_TO,
    JC_DIV_MORE
  } jcond_e;

  typedef struct packed {
    op_e              op;
    hold_e            hold;
    jcond_e           jc;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // Control word as seen by the datapath (op is NOP while the step holds)
  typedef struct packed {
    op_e op;
  } ctrl_t;

  // Condition flags from the datapath
  typedef struct packed {
    logic ph_trig;
    logic ph_wait;
    logic ph_meas;
    logic echo;
    logic echo_to_hit;
    logic div_more;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [THR_W-1:0] trigger_ticks;
    logic [THR_W-1:0] wait_timeout;
    logic [THR_W-1:0] echo_timeout;
    logic [THR_W-1:0] ticks_per_unit;
    logic [CNT_W-1:0] gap_ticks;
  } cfg_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_FETCH      = 5'd0;
  localparam logic [PC_W-1:0] PC_DISP_TRIG  = 5'd1;
  localparam logic [PC_W-1:0] PC_DISP_WAIT  = 5'd2;
  localparam logic [PC_W-1:0] PC_DISP_MEAS  = 5'd3;
  localparam logic [PC_W-1:0] PC_GAP        = 5'd4;
  localparam logic [PC_W-1:0] PC_TRIG       = 5'd5;
  localparam logic [PC_W-1:0] PC_WAIT       = 5'd6;
  localparam logic [PC_W-1:0] PC_WAIT_LOW   = 5'd7;
  localparam logic [PC_W-1:0] PC_RISE       = 5'd8;
  localparam logic [PC_W-1:0] PC_MEAS       = 5'd9;
  localparam logic [PC_W-1:0] PC_MEAS_UPD   = 5'd10;
  localparam logic [PC_W-1:0] PC_MEAS_TO    = 5'd11;
  localparam logic [PC_W-1:0] PC_MEAS_DONE  = 5'd12;
  localparam logic [PC_W-1:0] PC_REP_INIT   = 5'd13;
  localparam logic [PC_W-1:0] PC_DIV        = 5'd14;
  localparam logic [PC_W-1:0] PC_SAT        = 5'd15;
  localparam logic [PC_W-1:0] PC_HUND       = 5'd16;
  localparam logic [PC_W-1:0] PC_REM        = 5'd17;
  localparam logic [PC_W-1:0] PC_TENS       = 5'd18;
  localparam logic [PC_W-1:0] PC_ONES       = 5'd19;
  localparam logic [PC_W-1:0] PC_EMIT_HUND  = 5'd20;
  localparam logic [PC_W-1:0] PC_EMIT_TENS  = 5'd21;
  localparam logic [PC_W-1:0] PC_EMIT_ONES  = 5'd22;
  localparam logic [PC_W-1:0] PC_EMIT_CR    = 5'd23;
  localparam logic [PC_W-1:0] PC_EMIT_LF    = 5'd24;
  localparam logic [PC_W-1:0] PC_EMIT_IDLE  = 5'd25;
  localparam logic [PC_W-1:0] PC_EMIT_TRIG  = 5'd26;

  function automatic ucode_t uc(input op_e op, input hold_e hold, input jcond_e jc,
                                input logic [PC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.hold   = hold;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // Microcode program ROM
  function automatic ucode_t urs_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_FETCH:     w = uc(OP_LATCH,      HOLD_IN,   JC_NEXT,     PC_FETCH);
      PC_DISP_TRIG: w = uc(OP_NOP,        HOLD_NONE, JC_PH_TRIG,  PC_TRIG);
      PC_DISP_WAIT: w = uc(OP_NOP,        HOLD_NONE, JC_PH_WAIT,  PC_WAIT);
      PC_DISP_MEAS: w = uc(OP_NOP,        HOLD_NONE, JC_PH_MEAS,  PC_MEAS);
      PC_GAP:       w = uc(OP_GAP_UPD,    HOLD_NONE, JC_ALWAYS,   PC_EMIT_IDLE);
      PC_TRIG:      w = uc(OP_TRIG_UPD,   HOLD_NONE, JC_ALWAYS,   PC_EMIT_TRIG);
      PC_WAIT:      w = uc(OP_NOP,        HOLD_NONE, JC_ECHO,     PC_RISE);
      PC_WAIT_LOW:  w = uc(OP_WAIT_UPD,   HOLD_NONE, JC_ALWAYS,   PC_EMIT_IDLE);
      PC_RISE:      w = uc(OP_MEAS_START, HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_MEAS:      w = uc(OP_NOP,        HOLD_NONE, JC_NO_ECHO,  PC_REP_INIT);
      PC_MEAS_UPD:  w = uc(OP_MEAS_UPD,   HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_MEAS_TO:   w = uc(OP_NOP,        HOLD_NONE, JC_ECHO_TO,  PC_REP_INIT);
      PC_MEAS_DONE: w = uc(OP_NOP,        HOLD_NONE, JC_ALWAYS,   PC_EMIT_IDLE);
      PC_REP_INIT:  w = uc(OP_REP_INIT,   HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_DIV:       w = uc(OP_DIV_STEP,   HOLD_NONE, JC_DIV_MORE, PC_DIV);
      PC_SAT:       w = uc(OP_SAT,        HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_HUND:      w = uc(OP_HUND,       HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_REM:       w = uc(OP_REM,        HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_TENS:      w = uc(OP_TENS,       HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_ONES:      w = uc(OP_ONES,       HOLD_NONE, JC_NEXT,     PC_FETCH);
      PC_EMIT_HUND: w = uc(OP_EMIT_HUND,  HOLD_OUT,  JC_NEXT,     PC_FETCH);
      PC_EMIT_TENS: w = uc(OP_EMIT_TENS,  HOLD_OUT,  JC_NEXT,     PC_FETCH);
      PC_EMIT_ONES: w = uc(OP_EMIT_ONES,  HOLD_OUT,  JC_NEXT,     PC_FETCH);
      PC_EMIT_CR:   w = uc(OP_EMIT_CR,    HOLD_OUT,  JC_NEXT,     PC_FETCH);
      PC_EMIT_LF:   w = uc(OP_EMIT_LF,    HOLD_OUT,  JC_ALWAYS,   PC_FETCH);
      PC_EMIT_IDLE: w = uc(OP_EMIT_IDLE,  HOLD_OUT,  JC_ALWAYS,   PC_FETCH);
      PC_EMIT_TRIG: w = uc(OP_EMIT_TRIG,  HOLD_OUT,  JC_ALWAYS,   PC_FETCH);
      default:      w = uc(OP_NOP,        HOLD_NONE, JC_ALWAYS,   PC_FETCH);
    endcase
    return w;
  endfunction

endpackage

>>> design/urs_cfg_regs.sv
// ----------------------------------------------------------------------------
// urs_cfg_regs
// APB-style configuration registers: timing thresholds and report divisor.
// ----------------------------------------------------------------------------
module urs_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [urs_pkg::PADDR_W-1:0]  paddr,
  input  logic [urs_pkg::PDATA_W-1:0]  pwdata,
  output logic [urs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output urs_pkg::cfg_t                cfg_o
);
  import urs_pkg::*;

  cfg_t                cfg_q;
  logic [REGIDX_W-1:0] idx;
  logic                wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks  <= RST_TRIGGER_TICKS;
      cfg_q.wait_timeout   <= RST_WAIT_TIMEOUT;
      cfg_q.echo_timeout   <= RST_ECHO_TIMEOUT;
      cfg_q.ticks_per_unit <= RST_TICKS_PER_UNIT;
      cfg_q.gap_ticks      <= RST_GAP_TICKS;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIGGER_TICKS:  cfg_q.trigger_ticks  <= pwdata[THR_W-1:0];
        REG_WAIT_TIMEOUT:   cfg_q.wait_timeout   <= pwdata[THR_W-1:0];
        REG_ECHO_TIMEOUT:   cfg_q.echo_timeout   <= pwdata[THR_W-1:0];
        REG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= pwdata[THR_W-1:0];
        REG_GAP_TICKS:      cfg_q.gap_ticks      <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_TRIGGER_TICKS:  prdata = PDATA_W'(cfg_q.trigger_ticks);
      REG_WAIT_TIMEOUT:   prdata = PDATA_W'(cfg_q.wait_timeout);
      REG_ECHO_TIMEOUT:   prdata = PDATA_W'(cfg_q.echo_timeout);
      REG_TICKS_PER_UNIT: prdata = PDATA_W'(cfg_q.ticks_per_unit);
      REG_GAP_TICKS:      prdata = PDATA_W'(cfg_q.gap_ticks);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> design/urs_sequencer.sv
// ----------------------------------------------------------------------------
// urs_sequencer
// Step counter over the microcode ROM with hold and conditional jumps.
// ----------------------------------------------------------------------------
module urs_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  urs_pkg::status_t sts_i,
  output urs_pkg::ctrl_t   ctrl_o,
  output logic             in_stall_o
);
  import urs_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uw;
  logic            held;
  logic            jump;

  assign uw         = urs_rom(pc_q);
  assign in_stall_o = (pc_q != PC_FETCH);

  // Hold and jump decode
  always_comb begin
    unique case (uw.hold)
      HOLD_IN:  held = !in_valid_i;
      HOLD_OUT: held = sts_i.out_busy;
      default:  held = 1'b0;
    endcase
    unique case (uw.jc)
      JC_ALWAYS:   jump = 1'b1;
      JC_PH_TRIG:  jump = sts_i.ph_trig;
      JC_PH_WAIT:  jump = sts_i.ph_wait;
      JC_PH_MEAS:  jump = sts_i.ph_meas;
      JC_ECHO:     jump = sts_i.echo;
      JC_NO_ECHO:  jump = !sts_i.echo;
      JC_ECHO_TO:  jump = sts_i.echo_to_hit;
      JC_DIV_MORE: jump = sts_i.div_more;
      default:     jump = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    ctrl_o.op = held ? OP_NOP : uw.op;
    if (held) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef ASSERT_OFF
  // A fetched word always goes on to the phase dispatch
  a_fetch_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_FETCH && in_valid_i) |=> (pc_q == PC_DISP_TRIG))
    else $error("fetch did not advance to dispatch");

  // Divide loop runs exactly sixteen steps
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_REP_INIT) |=> ##16 (pc_q == PC_SAT))
    else $error("divide loop length wrong");

  // Output-holding steps never advance while the output is blocked
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.hold == HOLD_OUT && sts_i.out_busy) |=> $stable(pc_q))
    else $error("emit step advanced while output blocked");
`endif

endmodule

>>> design/urs_datapath.sv
// ----------------------------------------------------------------------------
// urs_datapath
// Phase and tick counters, restoring divider, digit split and output register.
// ----------------------------------------------------------------------------
module urs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urs_pkg::ctrl_t                ctrl_i,
  input  urs_pkg::cfg_t                 cfg_i,
  input  logic                          echo_level_i,
  output urs_pkg::status_t              sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trigger_level_o,
  output logic                          char_valid_o,
  output logic [urs_pkg::CHAR_W-1:0]    char_code_o,
  output logic                          last_o
);
  import urs_pkg::*;

  // Control state
  phase_e             phase_q;
  logic [CNT_W-1:0]   pcnt_q;
  logic [ECNT_W-1:0]  ecnt_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic               out_valid_q;

  // Working registers
  logic               echo_q;
  logic [ECNT_W-1:0]  dvd_q;
  logic [ECNT_W-1:0]  rem_q;
  logic [QSAT_W-1:0]  qs_q;
  logic [DIGIT_W-1:0] hund_q;
  logic [REM100_W-1:0] r100_q;
  logic [DIGIT_W-1:0] tens_q;
  logic [DIGIT_W-1:0] ones_q;
  logic               out_trig_q;
  logic               out_cv_q;
  logic [CHAR_W-1:0]  out_code_q;
  logic               out_last_q;

  logic [CNT_W-1:0]   pcnt_inc;
  logic [ECNT_W+1:0]  trial;
  logic [15:0]        hund_prod;
  logic [QSAT_W-1:0]  r100_full;
  logic [14:0]        tens_prod;
  logic [DIGIT_W-1:0] ones_val;
  logic               is_emit;
  logic               emit_trig;
  logic               emit_cv;
  logic [CHAR_W-1:0]  emit_code;
  logic               emit_last;

  // Arithmetic
  assign pcnt_inc  = pcnt_q + CNT_W'(1);
  assign trial     = {2'b00, rem_q[ECNT_W-2:0], dvd_q[ECNT_W-1]} - {2'b00, cfg_i.ticks_per_unit}
                     + {1'b0, rem_q[ECNT_W-1], {ECNT_W{1'b0}}};
  assign hund_prod = 16'(qs_q) * 16'(RECIP_100);
  assign r100_full = qs_q - QSAT_W'(hund_q) * QSAT_W'(HUNDRED);
  assign tens_prod = 15'(r100_q) * 15'(RECIP_10);
  assign ones_val  = DIGIT_W'(r100_q - REM100_W'(tens_q) * REM100_W'(TEN));

  // Status flags
  assign sts_o.ph_trig     = (phase_q == PH_TRIGGER);
  assign sts_o.ph_wait     = (phase_q == PH_WAIT);
  assign sts_o.ph_meas     = (phase_q == PH_MEASURE);
  assign sts_o.echo        = echo_q;
  assign sts_o.echo_to_hit = (pcnt_q >= CNT_W'(cfg_i.echo_timeout));
  assign sts_o.div_more    = (dcnt_q != DCNT_W'(1));
  assign sts_o.out_busy    = out_valid_q && out_stall_i;

  // Output word select
  always_comb begin
    is_emit   = 1'b1;
    emit_trig = 1'b0;
    emit_cv   = 1'b1;
    emit_last = 1'b0;
    emit_code = '0;
    case (ctrl_i.op)
      OP_EMIT_HUND: emit_code = CHAR_ZERO + CHAR_W'(hund_q);
      OP_EMIT_TENS: emit_code = CHAR_ZERO + CHAR_W'(tens_q);
      OP_EMIT_ONES: emit_code = CHAR_ZERO + CHAR_W'(ones_q);
      OP_EMIT_CR:   emit_code = CHAR_CR;
      OP_EMIT_LF: begin
        emit_code = CHAR_LF;
        emit_last = 1'b1;
      end
      OP_EMIT_IDLE, OP_EMIT_TRIG: begin
        emit_trig = (ctrl_i.op == OP_EMIT_TRIG);
        emit_cv   = 1'b0;
        emit_last = 1'b1;
      end
      default: is_emit = 1'b0;
    endcase
  end

  // Phase sequencing, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TRIGGER;
      pcnt_q      <= '0;
      ecnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        OP_TRIG_UPD: begin
          if (pcnt_inc >= CNT_W'(cfg_i.trigger_ticks)) begin
            phase_q <= PH_WAIT;
            pcnt_q  <= '0;
          end else begin
            pcnt_q  <= pcnt_inc;
          end
        end
        OP_WAIT_UPD: begin
          if (pcnt_inc >= CNT_W'(cfg_i.wait_timeout)) begin
            phase_q <= PH_MEASURE;
            pcnt_q  <= '0;
            ecnt_q  <= '0;
          end else begin
            pcnt_q  <= pcnt_inc;
          end
        end
        OP_GAP_UPD: begin
          if (pcnt_inc >= cfg_i.gap_ticks) begin
            phase_q <= PH_TRIGGER;
            pcnt_q  <= '0;
          end else begin
            pcnt_q  <= pcnt_inc;
          end
        end
        OP_MEAS_START: begin
          phase_q <= PH_MEASURE;
          pcnt_q  <= '0;
          ecnt_q  <= '0;
        end
        OP_MEAS_UPD: begin
          if (ecnt_q != ECNT_MAX) begin
            ecnt_q <= ecnt_q + ECNT_W'(1);
          end
          pcnt_q <= pcnt_inc;
        end
        OP_REP_INIT: begin
          pcnt_q  <= '0;
          phase_q <= (cfg_i.gap_ticks == '0) ? PH_TRIGGER : PH_GAP;
          dcnt_q  <= DIV_STEPS;
        end
        OP_DIV_STEP: dcnt_q <= dcnt_q - DCNT_W'(1);
        default: ;
      endcase
      if (is_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider, digit split and output payload
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LATCH: echo_q <= echo_level_i;
      OP_REP_INIT: begin
        dvd_q <= ecnt_q;
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        if (!trial[ECNT_W+1]) begin
          rem_q <= trial[ECNT_W-1:0];
          dvd_q <= {dvd_q[ECNT_W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[ECNT_W-2:0], dvd_q[ECNT_W-1]};
          dvd_q <= {dvd_q[ECNT_W-2:0], 1'b0};
        end
      end
      OP_SAT:  qs_q   <= (dvd_q > QUOT_MAX) ? QSAT_W'(QUOT_MAX) : dvd_q[QSAT_W-1:0];
      OP_HUND: hund_q <= hund_prod[15:12];
      OP_REM:  r100_q <= r100_full[REM100_W-1:0];
      OP_TENS: tens_q <= tens_prod[14:11];
      OP_ONES: ones_q <= ones_val;
      default: ;
    endcase
    if (is_emit) begin
      out_trig_q <= emit_trig;
      out_cv_q   <= emit_cv;
      out_code_q <= emit_code;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = out_trig_q;
  assign char_valid_o    = out_cv_q;
  assign char_code_o     = out_code_q;
  assign last_o          = out_last_q;

`ifndef ASSERT_OFF
  // Split digits are decimal when they are sent
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_EMIT_HUND) |-> (hund_q <= 4'd9 && tens_q <= 4'd9 && ones_q <= 4'd9))
    else $error("report digit out of range");

  // A word without a character is always the only word of its tick
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_cv_q) |-> out_last_q)
    else $error("plain word not marked last");

  // The report leaves the measure phase with a cleared phase counter
  a_rep_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_REP_INIT) |=> (phase_q != PH_MEASURE && pcnt_q == '0))
    else $error("report did not leave measure phase");
`endif

endmodule

>>> design/ultrasonic_range_sequencer_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_sequencer_unit
// Ultrasonic echo-ranging sequencer: trigger, wait, measure and gap phases per
// timer tick, with an ASCII distance report at the end of each measurement.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                words per tick
//  in       input      in_valid_i / in_stall_o  one tick word (echo_level_i)
//  out      output     out_valid_o / out_stall_i one, or five on a report tick
//  cfg      input      APB psel/penable/pwrite  register write or read
//
// A tick holds the sequencer from fetch through the microcode steps of its
// phase; its word is registered at the emit step that ends the tick. The tick
// that ends a measurement also runs the restoring divide, the digit split and
// the emit steps.
// Reset brings the sequencer to its fetch step, the trigger phase, zero counts
// and the register defaults. A stalled output holds the emit step, and the
// input stays stalled until the program returns to fetch.
// ----------------------------------------------------------------------------
module ultrasonic_range_sequencer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         echo_level_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         trigger_level_o,
  output logic                         char_valid_o,
  output logic [urs_pkg::CHAR_W-1:0]   char_code_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [urs_pkg::PADDR_W-1:0]  paddr,
  input  logic [urs_pkg::PDATA_W-1:0]  pwdata,
  output logic [urs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import urs_pkg::*;

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t sts;

  urs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  urs_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  urs_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cfg_i           (cfg),
    .echo_level_i    (echo_level_i),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .trigger_level_o (trigger_level_o),
    .char_valid_o    (char_valid_o),
    .char_code_o     (char_code_o),
    .last_o          (last_o)
  );

endmodule
